FILE: hw/rtl/tnsa_pkg.sv
`default_nettype none
package tnsa_pkg;

  // Defaults for the top-level parameters
  localparam int PIXEL_BYTES_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Shared divider geometry: signed dividend, unsigned divisor, step count
  localparam int DIV_W = 33;
  localparam int REM_W = 23;
  localparam int CNT_W = 6;

  // Edge modes
  localparam logic [2:0] EDGE_CLAMP = 3'd1;
  localparam logic [2:0] EDGE_LOOP  = 3'd2;
  localparam logic [2:0] EDGE_BLACK = 3'd3;
  localparam logic [2:0] EDGE_WHITE = 3'd4;

  // Result outcomes
  localparam logic [1:0] OUT_FETCH = 2'd0;
  localparam logic [1:0] OUT_BLACK = 2'd1;
  localparam logic [1:0] OUT_WHITE = 2'd2;
  localparam logic [1:0] OUT_ZERO  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_LEFT    = 3'd0;
  localparam logic [2:0] REG_TOP     = 3'd1;
  localparam logic [2:0] REG_SPAN_X  = 3'd2;
  localparam logic [2:0] REG_SPAN_Y  = 3'd3;
  localparam logic [2:0] REG_TILE_W  = 3'd4;
  localparam logic [2:0] REG_TILE_H  = 3'd5;
  localparam logic [2:0] REG_SHIFT_X = 3'd6;
  localparam logic [2:0] REG_SHIFT_Y = 3'd7;

  // Effective configuration (zero spans and tile sizes already read as one)
  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic [22:0]        span_x;
    logic [22:0]        span_y;
    logic [10:0]        tile_w;
    logic [10:0]        tile_h;
    logic signed [23:0] shift_x;
    logic signed [23:0] shift_y;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic [REM_W-1:0]        divisor;
    logic [CNT_W-1:0]        nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tnsa_if.sv
`default_nettype none
interface tnsa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [2:0]         edge_mode;
  modport source (output valid, coord_x, coord_y, edge_mode, input ready);
  modport sink (input valid, coord_x, coord_y, edge_mode, output ready);
endinterface

interface tnsa_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic signed [23:0] tile_col;
  logic signed [23:0] tile_row;
  logic [23:0]        byte_offset;
  logic               tile_hit;
  modport source (output valid, outcome, tile_col, tile_row, byte_offset, tile_hit,
                  input ready);
  modport sink (input valid, outcome, tile_col, tile_row, byte_offset, tile_hit,
                output ready);
endinterface

interface tnsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tiled_nearest_sample_address.sv
`default_nettype none
// Nearest-sample tile addressing. Each sample beat carries a fixed-point
// coordinate pair and an edge mode; each produces exactly one result beat
// with an outcome (fetch or black/white/zero fill), the floor-divided tile
// column and row, the byte offset within the tile and a hot-tile hit flag.
// One sample is worked on at a time and sample.ready is low until its result
// has been handed to the output register, which holds it while the next
// sample is taken. Timing is set by one shared restoring divider that yields
// one quotient bit per cycle: an in-range or clamped fetch runs two tile
// divisions plus setup, multiply and emit, a loop fetch runs two more wrap
// divisions before those, a fill result skips the divider, and the output
// register may in any case wait on result.ready.
// Configuration writes are taken every cycle but belong to idle periods only.
module tiled_nearest_sample_address import tnsa_pkg::*; #(
  parameter int PIXEL_BYTES = PIXEL_BYTES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tnsa_sample_if.sink   sample,
  tnsa_result_if.source result,
  tnsa_cfg_if.sink      cfg
);

  cfg_t     conf;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration registers
  tnsa_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .conf (conf)
  );

  // Shared floor divider
  tnsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and datapath
  tnsa_seq #(
    .PIXEL_BYTES (PIXEL_BYTES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .result  (result),
    .conf    (conf),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/tnsa_cfg.sv
`default_nettype none
module tnsa_cfg import tnsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tnsa_cfg_if.sink   cfg,
  output cfg_t       conf
);

  logic signed [23:0] left;
  logic signed [23:0] top;
  logic [22:0]        span_x;
  logic [22:0]        span_y;
  logic [10:0]        tile_w;
  logic [10:0]        tile_h;
  logic signed [23:0] shift_x;
  logic signed [23:0] shift_y;

  assign cfg.ready = 1'b1;

  // Write one register per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      left    <= '0;
      top     <= '0;
      span_x  <= 23'd1024;
      span_y  <= 23'd1024;
      tile_w  <= 11'd128;
      tile_h  <= 11'd64;
      shift_x <= '0;
      shift_y <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LEFT:    left    <= cfg.data;
        REG_TOP:     top     <= cfg.data;
        REG_SPAN_X:  span_x  <= cfg.data[22:0];
        REG_SPAN_Y:  span_y  <= cfg.data[22:0];
        REG_TILE_W:  tile_w  <= cfg.data[10:0];
        REG_TILE_H:  tile_h  <= cfg.data[10:0];
        REG_SHIFT_X: shift_x <= cfg.data;
        REG_SHIFT_Y: shift_y <= cfg.data;
      endcase
    end
  end

  // Read a zero span or tile size as one
  always_comb begin
    conf.left    = left;
    conf.top     = top;
    conf.span_x  = (span_x == '0) ? 23'd1 : span_x;
    conf.span_y  = (span_y == '0) ? 23'd1 : span_y;
    conf.tile_w  = (tile_w == '0) ? 11'd1 : tile_w;
    conf.tile_h  = (tile_h == '0) ? 11'd1 : tile_h;
    conf.shift_x = shift_x;
    conf.shift_y = shift_y;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tnsa_div.sv
`default_nettype none
module tnsa_div import tnsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] q;
  logic [REM_W-1:0] r;
  logic [REM_W-1:0] d;
  logic             neg;

  logic [DIV_W-1:0] mag;
  logic [REM_W:0]   shifted;
  logic [REM_W+1:0] diff;
  logic             ge;

  // Magnitude of the dividend, and one restoring step
  assign mag     = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : req.dividend;
  assign shifted = {r, q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d};
  assign ge      = !diff[REM_W+1];

  // Sequence: load, one quotient bit per cycle, then floor fix-up
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg   <= req.dividend[DIV_W-1];
            d     <= req.divisor;
            r     <= '0;
            q     <= mag << (CNT_W'(DIV_W) - req.nbits);
            cnt   <= req.nbits;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          r   <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
          q   <= {q[DIV_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          // Round toward minus infinity, keep the remainder non-negative
          if (neg && (r != '0)) begin
            rsp.quot <= ~q;
            rsp.rem  <= d - r;
          end else if (neg) begin
            rsp.quot <= -q;
            rsp.rem  <= r;
          end else begin
            rsp.quot <= q;
            rsp.rem  <= r;
          end
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == D_IDLE)
    else $error("divider started while busy");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.rem < d)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("divider done held for more than one cycle");

endmodule
`default_nettype wire

FILE: hw/rtl/tnsa_seq.sv
`default_nettype none
module tnsa_seq import tnsa_pkg::*; #(
  parameter int PIXEL_BYTES = PIXEL_BYTES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  tnsa_sample_if.sink   sample,
  tnsa_result_if.source result,
  input  cfg_t          conf,
  output div_req_t      div_req,
  input  div_rsp_t      div_rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WRAPX, S_WRAPY, S_SHIFT, S_COL, S_ROW, S_MUL, S_SUM, S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] WRAP_BITS = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] TILE_BITS = CNT_W'(26);

  state_t             state;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic [2:0]         mode;
  logic signed [25:0] ty;
  logic [10:0]        offx;
  logic [10:0]        offy;
  logic [21:0]        prod;
  logic [1:0]         outc;
  logic [23:0]        col;
  logic [23:0]        row;
  logic [23:0]        boff;
  logic               hot_valid;
  logic [23:0]        hot_col;
  logic [23:0]        hot_row;
  logic               res_valid;
  logic [1:0]         res_outcome;
  logic [23:0]        res_col;
  logic [23:0]        res_row;
  logic [23:0]        res_boff;
  logic               res_hit;

  logic signed [32:0] x33, y33, left33, top33, limx33, limy33;
  logic signed [32:0] wrapx, wrapy;
  logic signed [25:0] tx_w, ty_w;
  logic               outside;
  logic [21:0]        sum;
  logic               hit_w;
  logic               emit;
  logic               div_go;

  assign x33    = 33'(x);
  assign y33    = 33'(y);
  assign left33 = 33'(conf.left);
  assign top33  = 33'(conf.top);
  assign limx33 = left33 + 33'(conf.span_x);
  assign limy33 = top33 + 33'(conf.span_y);
  assign wrapx  = left33 + 33'(div_rsp.rem);
  assign wrapy  = top33 + 33'(div_rsp.rem);
  assign tx_w   = 26'($signed(x[24:0])) + 26'(conf.shift_x);
  assign ty_w   = 26'($signed(y[24:0])) + 26'(conf.shift_y);
  assign sum    = prod + 22'(offx);

  assign outside = (x33 < left33) || (y33 < top33) || (x33 >= limx33) || (y33 >= limy33);
  assign hit_w   = (outc == OUT_FETCH) && hot_valid && (hot_col == col) && (hot_row == row);
  assign emit    = (state == S_EMIT) && (!res_valid || result.ready);

  // Start the divider for a wrap or a tile split
  assign div_go = ((state == S_CHECK) && outside && (mode == EDGE_LOOP)) ||
                  ((state == S_WRAPX) && div_rsp.done) ||
                  (state == S_SHIFT) ||
                  ((state == S_COL) && div_rsp.done);

  assign sample.ready       = (state == S_IDLE);
  assign result.valid       = res_valid;
  assign result.outcome     = res_outcome;
  assign result.tile_col    = res_col;
  assign result.tile_row    = res_row;
  assign result.byte_offset = res_boff;
  assign result.tile_hit    = res_hit;

  // Sequencer: edge handling, wrap and tile floor divisions, offset, hot tile
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      hot_valid     <= 1'b0;
      hot_col       <= '0;
      hot_row       <= '0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= div_go;
      res_valid     <= emit || (res_valid && !result.ready);
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            x     <= sample.coord_x >>> FRAC_BITS;
            y     <= sample.coord_y >>> FRAC_BITS;
            mode  <= sample.edge_mode;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!outside) begin
            state <= S_SHIFT;
          end else begin
            unique case (mode)
              EDGE_CLAMP: begin
                if (x33 < left33)       x <= left33[31:0];
                else if (x33 >= limx33) x <= 32'(limx33 - 33'sd1);
                if (y33 < top33)        y <= top33[31:0];
                else if (y33 >= limy33) y <= 32'(limy33 - 33'sd1);
                state <= S_SHIFT;
              end
              EDGE_LOOP: begin
                div_req.dividend <= x33 - left33;
                div_req.divisor  <= conf.span_x;
                div_req.nbits    <= WRAP_BITS;
                state            <= S_WRAPX;
              end
              default: begin
                priority case (mode)
                  EDGE_BLACK: outc <= OUT_BLACK;
                  EDGE_WHITE: outc <= OUT_WHITE;
                  default:    outc <= OUT_ZERO;
                endcase
                col   <= '0;
                row   <= '0;
                boff  <= '0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_WRAPX: begin
          if (div_rsp.done) begin
            x                <= wrapx[31:0];
            div_req.dividend <= y33 - top33;
            div_req.divisor  <= conf.span_y;
            div_req.nbits    <= WRAP_BITS;
            state            <= S_WRAPY;
          end
        end
        S_WRAPY: begin
          if (div_rsp.done) begin
            y     <= wrapy[31:0];
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          ty               <= ty_w;
          div_req.dividend <= DIV_W'(tx_w);
          div_req.divisor  <= REM_W'(conf.tile_w);
          div_req.nbits    <= TILE_BITS;
          state            <= S_COL;
        end
        S_COL: begin
          if (div_rsp.done) begin
            col              <= div_rsp.quot[23:0];
            offx             <= div_rsp.rem[10:0];
            div_req.dividend <= DIV_W'(ty);
            div_req.divisor  <= REM_W'(conf.tile_h);
            div_req.nbits    <= TILE_BITS;
            state            <= S_ROW;
          end
        end
        S_ROW: begin
          if (div_rsp.done) begin
            row   <= div_rsp.quot[23:0];
            offy  <= div_rsp.rem[10:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 22'(offy) * 22'(conf.tile_w);
          state <= S_SUM;
        end
        S_SUM: begin
          // Constant scale by the pixel size, wrap to 24 bits
          boff  <= 24'(32'(sum) * 32'(PIXEL_BYTES));
          outc  <= OUT_FETCH;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            res_outcome <= outc;
            res_col     <= col;
            res_row     <= row;
            res_boff    <= boff;
            res_hit     <= hit_w;
            // Load the hot tile on a fetch miss
            if ((outc == OUT_FETCH) && !hit_w) begin
              hot_valid <= 1'b1;
              hot_col   <= col;
              hot_row   <= row;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("second sample accepted while one is at work");

  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_outcome != OUT_FETCH)) |->
      (res_col == '0) && (res_row == '0) && (res_boff == '0) && !res_hit)
    else $error("fill result carries tile fields");

  a_hit_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_hit) |-> hot_valid && (hot_col == res_col) && (hot_row == res_row))
    else $error("hit reported without a matching hot tile");

endmodule
`default_nettype wire

FILE: sim/tiled_nearest_sample_address_test.sv
`timescale 1ns / 1ps

module tiled_nearest_sample_address_test;
  import tnsa_pkg::*;

  localparam int CYCLE_LIMIT     = 1500000;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int FRAC_ONE        = 1 << FRAC_BITS_DEF;
  localparam logic [2:0] EDGE_NONE = 3'd0;

  typedef struct {
    logic [1:0]  outcome;
    logic [23:0] tile_col;
    logic [23:0] tile_row;
    logic [23:0] byte_offset;
    logic        tile_hit;
  } tile_addr_t;

  // Address predictor: register copy, hot tile, and the queue of addresses still owed
  class tile_addr_scoreboard;
    logic signed [23:0] left, top, shift_x, shift_y;
    logic [22:0]        span_x, span_y;
    logic [10:0]        tile_w, tile_h;
    bit                 hot_valid;
    logic [23:0]        hot_col, hot_row;
    tile_addr_t         expected_q[$];
    int                 results_seen;
    int                 errors;

    function new();
      left = '0;
      top = '0;
      span_x = 23'd1024;
      span_y = 23'd1024;
      tile_w = 11'd128;
      tile_h = 11'd64;
      shift_x = '0;
      shift_y = '0;
      hot_valid = 1'b0;
      hot_col = '0;
      hot_row = '0;
      results_seen = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(logic [2:0] index, logic [23:0] data);
      case (index)
        REG_LEFT:    left    = data;
        REG_TOP:     top     = data;
        REG_SPAN_X:  span_x  = data[22:0];
        REG_SPAN_Y:  span_y  = data[22:0];
        REG_TILE_W:  tile_w  = data[10:0];
        REG_TILE_H:  tile_h  = data[10:0];
        REG_SHIFT_X: shift_x = data;
        REG_SHIFT_Y: shift_y = data;
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if (a % d != 0 && a < 0) q--;
      return q;
    endfunction

    function void note_sample(logic signed [31:0] cx, logic signed [31:0] cy,
                              logic [2:0] mode);
      longint x, y, l, t, sx, sy, tw, th, tx, ty, col, row, offx, offy;
      tile_addr_t r;
      x = floor_div(longint'(cx), FRAC_ONE);
      y = floor_div(longint'(cy), FRAC_ONE);
      l = longint'(left);
      t = longint'(top);
      sx = longint'(span_x);
      sy = longint'(span_y);
      tw = longint'(tile_w);
      th = longint'(tile_h);
      // zero spans and tile sizes read as one
      if (sx == 0) sx = 1;
      if (sy == 0) sy = 1;
      if (tw == 0) tw = 1;
      if (th == 0) th = 1;
      r.outcome = OUT_FETCH;
      r.tile_col = '0;
      r.tile_row = '0;
      r.byte_offset = '0;
      r.tile_hit = 1'b0;

      // Resolve points outside the valid rectangle
      if (x < l || y < t || x >= l + sx || y >= t + sy) begin
        case (mode)
          EDGE_CLAMP: begin
            if (x < l) x = l;
            if (x > l + sx - 1) x = l + sx - 1;
            if (y < t) y = t;
            if (y > t + sy - 1) y = t + sy - 1;
          end
          EDGE_LOOP: begin
            x = x - floor_div(x - l, sx) * sx;
            y = y - floor_div(y - t, sy) * sy;
          end
          EDGE_BLACK: r.outcome = OUT_BLACK;
          EDGE_WHITE: r.outcome = OUT_WHITE;
          default:    r.outcome = OUT_ZERO;
        endcase
      end

      // Split the shifted point into tile and offset, then look up the hot tile
      if (r.outcome == OUT_FETCH) begin
        tx = x + longint'(shift_x);
        ty = y + longint'(shift_y);
        col = floor_div(tx, tw);
        row = floor_div(ty, th);
        offx = tx - col * tw;
        offy = ty - row * th;
        r.tile_col = col[23:0];
        r.tile_row = row[23:0];
        r.byte_offset = 24'((offy * tw + offx) * PIXEL_BYTES_DEF);
        r.tile_hit = hot_valid && hot_col == r.tile_col && hot_row == r.tile_row;
        if (!r.tile_hit) begin
          hot_valid = 1'b1;
          hot_col = r.tile_col;
          hot_row = r.tile_row;
        end
      end
      expected_q.push_back(r);
    endfunction

    task check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %h want %h",
                                  results_seen, name, got, want));
    endtask

    task check_result(tile_addr_t got);
      tile_addr_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no sample pending",
                                  results_seen));
        return;
      end
      want = expected_q.pop_front();
      check_field("outcome", 24'(got.outcome), 24'(want.outcome));
      check_field("tile_col", got.tile_col, want.tile_col);
      check_field("tile_row", got.tile_row, want.tile_row);
      check_field("byte_offset", got.byte_offset, want.byte_offset);
      check_field("tile_hit", 24'(got.tile_hit), 24'(want.tile_hit));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tnsa_sample_if sample_bus();
  tnsa_result_if result_bus();
  tnsa_cfg_if    cfg_bus();

  tiled_nearest_sample_address DUT (
    .clk(clk),
    .rst(rst),
    .sample(sample_bus),
    .result(result_bus),
    .cfg(cfg_bus)
  );

  tile_addr_scoreboard addr_sb = new();
  int                  send_idle_pct = 19;
  int                  recv_idle_pct = 68;
  logic                hold_req = 1'b0;
  logic                hold_off = 1'b0;
  int                  items_sent = 0;
  int                  cycle_count = 0;
  logic [31:0]         last_x = '0;
  logic [31:0]         last_y = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drop ready at random, and for the whole hold-off stretch
  always @(posedge clk) begin
    if (rst || hold_off) result_bus.ready <= 1'b0;
    else result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hold the result side off long enough for the block to stall its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watch every beat: register writes, accepted samples, delivered results
  always @(posedge clk) begin
    tile_addr_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.outcome = result_bus.outcome;
      got.tile_col = result_bus.tile_col;
      got.tile_row = result_bus.tile_row;
      got.byte_offset = result_bus.byte_offset;
      got.tile_hit = result_bus.tile_hit;
      addr_sb.check_result(got);
    end
    if (!rst && cfg_bus.valid && cfg_bus.ready)
      addr_sb.write_reg(cfg_bus.index, cfg_bus.data);
    if (!rst && sample_bus.valid && sample_bus.ready)
      addr_sb.note_sample(sample_bus.coord_x, sample_bus.coord_y, sample_bus.edge_mode);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(logic signed [31:0] cx, logic signed [31:0] cy,
                             logic [2:0] mode);
    // idle now and then, sometimes long enough to span a whole item
    if ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(7) == 0) ? 120 : 4)) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.coord_x <= cx;
    sample_bus.coord_y <= cy;
    sample_bus.edge_mode <= mode;
    do @(posedge clk); while (!sample_bus.ready);
    items_sent++;
    last_x = cx;
    last_y = cy;
  endtask

  task automatic load_reg(logic [2:0] index, logic [23:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Stop offering, wait for every owed result, then let the block settle
  task automatic drain(int settle);
    sample_bus.valid <= 1'b0;
    while (addr_sb.results_seen < items_sent) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One coordinate axis: near the rectangle edges, inside it, or anywhere at all
  function automatic logic [31:0] pick_coord(longint base, longint span, logic [31:0] last);
    longint p;
    case ($urandom_range(11))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      3: return {last[31:FRAC_BITS_DEF], FRAC_BITS_DEF'($urandom())};
      4: p = base - 1 - longint'($urandom_range(64));
      5: p = base + span + longint'($urandom_range(64));
      6: p = base + longint'($urandom_range(3));
      7: p = base + span - 1 - longint'($urandom_range(3));
      default: p = base + longint'($urandom_range(32'(span - 1)));
    endcase
    return 32'(p * FRAC_ONE + longint'($urandom_range(FRAC_ONE - 1)));
  endfunction

  function automatic logic [2:0] pick_mode();
    case ($urandom_range(9))
      0, 1, 2: return EDGE_CLAMP;
      3, 4, 5: return EDGE_LOOP;
      default: return 3'($urandom());
    endcase
  endfunction

  // Load a full register set while idle, then run random samples against it
  task automatic run_phase(logic signed [23:0] left, logic signed [23:0] top,
                           logic [22:0] span_x, logic [22:0] span_y,
                           logic [10:0] tile_w, logic [10:0] tile_h,
                           logic signed [23:0] shift_x, logic signed [23:0] shift_y);
    longint sx, sy;
    sx = (span_x == '0) ? 64'sd1 : longint'(span_x);
    sy = (span_y == '0) ? 64'sd1 : longint'(span_y);
    load_reg(REG_LEFT, left);
    load_reg(REG_TOP, top);
    load_reg(REG_SPAN_X, 24'(span_x));
    load_reg(REG_SPAN_Y, 24'(span_y));
    load_reg(REG_TILE_W, 24'(tile_w));
    load_reg(REG_TILE_H, 24'(tile_h));
    load_reg(REG_SHIFT_X, shift_x);
    load_reg(REG_SHIFT_Y, shift_y);
    cfg_bus.valid <= 1'b0;
    repeat (ITEMS_PER_PHASE)
      send_sample(pick_coord(longint'(left), sx, last_x),
                  pick_coord(longint'(top), sy, last_y), pick_mode());
    drain(4);
  endtask

  initial begin
    int m;
    sample_bus.valid <= 1'b0;
    sample_bus.coord_x <= '0;
    sample_bus.coord_y <= '0;
    sample_bus.edge_mode <= EDGE_NONE;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_LEFT;
    cfg_bus.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed samples on the reset rectangle (0..1023 square, 128x64 tiles)
    send_sample(0, 0, EDGE_NONE);
    send_sample(32'sh80, 32'shC0, EDGE_NONE);
    send_sample(1024 * FRAC_ONE - 1, 1024 * FRAC_ONE - 1, EDGE_NONE);
    send_sample(-1, 0, EDGE_NONE);
    send_sample(1024 * FRAC_ONE, 5 * FRAC_ONE, EDGE_NONE);
    // every edge code, unused ones included, on a point outside both edges
    for (m = 0; m < 8; m++)
      send_sample(-3 * FRAC_ONE - 128, 2000 * FRAC_ONE + 64, 3'(m));
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, EDGE_CLAMP);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, EDGE_CLAMP);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, EDGE_LOOP);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, EDGE_LOOP);
    send_sample(-1, -1, EDGE_LOOP);
    send_sample(32'sh8000_0000, 32'sh8000_0000, EDGE_WHITE);
    send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, EDGE_BLACK);
    send_sample(500 * FRAC_ONE, 70 * FRAC_ONE, EDGE_LOOP);
    drain(4);

    // tiny rectangle and tiles: clamp and wrap dominate
    run_phase(-24'sd5, 24'sd3, 23'd7, 23'd5, 11'd3, 11'd2, -24'sd10, 24'sd7);
    // widest rectangle, unit and zero tiles: tile indexes wrap high
    run_phase(24'sd0, 24'sd0, 23'h7fffff, 23'h7fffff, 11'd1, 11'd0,
              24'sh7fffff, 24'sh7fffff);

    send_idle_pct = 68;
    recv_idle_pct <= 19;
    hold_req <= 1'b1;
    // most negative corner, largest tiles: tile indexes go negative, byte offset wraps
    run_phase(24'sh800000, 24'sh800000, 23'h7fffff, 23'd1, 11'd2047, 11'd2047,
              24'sh800000, 24'sh800000);
    // zero spans at the far corner
    run_phase(24'sh7fffff, 24'sh7fffff, 23'd0, 23'd0, 11'd1024, 11'd1024,
              24'sd0, -24'sd1);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(24'($urandom()), 24'($urandom()), 23'($urandom_range(1, 4096)),
              23'($urandom_range(1, 4096)), 11'($urandom_range(1, 2047)),
              11'($urandom_range(1, 2047)), 24'($urandom()), 24'($urandom()));

    drain(16);
    if (addr_sb.expected_q.size() != 0)
      addr_sb.report_mismatch($sformatf("%0d results never arrived",
                                        addr_sb.expected_q.size()));
    if (addr_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
